FILE: sv/txdq_pkg.sv
// shared types and codes for the transmit descriptor queue
package txdq_pkg;

    localparam int ADDR_W   = 32;
    localparam int LENGTH_W = 16;
    localparam int DESC_W   = ADDR_W + LENGTH_W;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DONE    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_ENQUEUED     = 2'd0,
        STAT_REFUSED_FULL = 2'd1,
        STAT_DONE_RETIRED = 2'd2,
        STAT_DONE_IGNORED = 2'd3
    } t_status;

    typedef enum logic {
        ST_ACCEPT = 1'b0,
        ST_READ   = 1'b1
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   msg_addr;
        logic [LENGTH_W-1:0] msg_length;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic                start_valid;
        logic [ADDR_W-1:0]   start_addr;
        logic [LENGTH_W-1:0] start_length;
    } t_out_word;

endpackage

FILE: sv/txdq_ram.sv
// generic single-port-write, single-port-read ram with registered read
module txdq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/tx_descriptor_queue.sv
// top level of the transmit descriptor queue
//
// ring queue of transmit descriptors (address, length) in front of a dma
// serial transmitter. one input word is either an enqueue or a transfer done
// event; every accepted word gives exactly one output word with a status and,
// when a transfer is started, the descriptor of that transfer.
// channels: valid/stall on both sides, a word moves when valid is high and
// stall is low. the output word sits in a register, so a new input word is
// taken in the same cycle the previous result is taken by the receiver.
// the result of an enqueue, a refused enqueue, an ignored done and a done
// that empties the queue is loaded into the output register at acceptance. a
// done that starts the next descriptor reads it into the registered read port
// of the descriptor ram, and the read state then loads the output register.
// throughput: one word per cycle while the receiver does not stall; the input
// stalls in that read state, as the descriptor ram read is registered.
// a stalled receiver holds the output word and the input side stalls until
// the output register can be reloaded.
// reset clears the indices, the full and busy flags and the output valid;
// the descriptor ram is not cleared, only slots that were written are read.
module tx_descriptor_queue
    import txdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // control state
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_full, n_full;
    logic             r_busy, n_busy;
    logic             r_out_valid, n_out_valid;
    // payload
    t_out_word        r_out_word, n_out_word;

    // ram side
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [DESC_W-1:0] ram_rd_data;

    logic             out_free;
    logic             in_accept;
    logic [IDX_W-1:0] wr_idx_next;
    logic [IDX_W-1:0] rd_idx_next;

    // ring index wrap, works for depths that are not a power of two
    assign wr_idx_next = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
    assign rd_idx_next = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;

    // output register empty or emptied at this edge
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_ACCEPT) && out_free);
    assign in_accept = i_in_valid && !o_in_stall;

    // descriptor store
    txdq_ram #(
        .WIDTH (DESC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_idx),
        .i_wr_data ({i_in_word.msg_addr, i_in_word.msg_length}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (rd_idx_next),
        .o_rd_data (ram_rd_data)
    );

    // next state: only a done that leaves a descriptor queued waits for the ram
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCEPT: begin
                if (in_accept && i_in_word.op == OP_DONE && r_busy
                        && rd_idx_next != r_wr_idx) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_ACCEPT;
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_full      = r_full;
        n_busy      = r_busy;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        unique case (r_state)
            ST_ACCEPT: begin
                if (in_accept) begin
                    n_out_valid             = 1'b1;
                    n_out_word.start_valid  = 1'b0;
                    n_out_word.start_addr   = '0;
                    n_out_word.start_length = '0;
                    if (i_in_word.op == OP_ENQUEUE) begin
                        if (r_full) begin
                            n_out_word.status = STAT_REFUSED_FULL;
                        end else begin
                            ram_wr_en         = 1'b1;
                            n_wr_idx          = wr_idx_next;
                            n_full            = (wr_idx_next == r_rd_idx);
                            n_out_word.status = STAT_ENQUEUED;
                            // idle means empty, so the head is this very word
                            if (!r_busy) begin
                                n_busy                  = 1'b1;
                                n_out_word.start_valid  = 1'b1;
                                n_out_word.start_addr   = i_in_word.msg_addr;
                                n_out_word.start_length = i_in_word.msg_length;
                            end
                        end
                    end else begin
                        if (!r_busy) begin
                            n_out_word.status = STAT_DONE_IGNORED;
                        end else begin
                            n_full            = 1'b0;
                            n_rd_idx          = rd_idx_next;
                            n_out_word.status = STAT_DONE_RETIRED;
                            if (rd_idx_next == r_wr_idx) begin
                                n_busy = 1'b0;
                            end else begin
                                // next head comes from the ram in the read state
                                n_out_valid = 1'b0;
                                ram_rd_en   = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                n_out_valid             = 1'b1;
                n_out_word.status       = STAT_DONE_RETIRED;
                n_out_word.start_valid  = 1'b1;
                n_out_word.start_addr   = ram_rd_data[DESC_W-1:LENGTH_W];
                n_out_word.start_length = ram_rd_data[LENGTH_W-1:0];
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_full      <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_full      <= n_full;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a full queue always has a transfer in flight
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_busy)
        else $error("queue full while transmitter idle");

    // full and idle both mean the indices meet
    a_idx_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full || !r_busy) |-> (r_wr_idx == r_rd_idx))
        else $error("indices apart while full or idle");

    // the ram read cycle never finds the output register occupied
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("output register busy during descriptor read");

    // a read is always followed by a start of the read descriptor
    a_read_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_out_valid && r_out_word.start_valid))
        else $error("descriptor read without start");

endmodule

FILE: verif/tx_descriptor_queue_tb.sv
// self-checking testbench for the transmit descriptor queue
`timescale 1ns / 1ps

module tx_descriptor_queue_tb;
    import txdq_pkg::*;

    localparam int QDEPTH         = 32;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int SEGMENT_ITEMS  = 125;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    // idling patterns applied per stimulus segment
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_phase;

    // descriptor ring predictor: mirrors the queue state and keeps the
    // output words still owed by the block, oldest first
    class descriptor_ring_model;
        logic [ADDR_W-1:0]   slot_addr [QDEPTH];
        logic [LENGTH_W-1:0] slot_len  [QDEPTH];
        int unsigned         wr_idx;
        int unsigned         rd_idx;
        bit                  queue_full;
        bit                  tx_busy;
        t_out_word           owed_words [$];
        int                  errors;
        int                  n_enqueued;
        int                  n_refused;
        int                  n_retired;
        int                  n_ignored;
        int                  n_starts;
        int                  n_full_hits;
        int                  n_checked;

        function new();
            wr_idx      = 0;
            rd_idx      = 0;
            queue_full  = 0;
            tx_busy     = 0;
            errors      = 0;
            n_enqueued  = 0;
            n_refused   = 0;
            n_retired   = 0;
            n_ignored   = 0;
            n_starts    = 0;
            n_full_hits = 0;
            n_checked   = 0;
        endfunction

        // start the transfer of the head-of-queue descriptor
        function void load_start(inout t_out_word r);
            r.start_valid  = 1'b1;
            r.start_addr   = slot_addr[rd_idx];
            r.start_length = slot_len[rd_idx];
            n_starts++;
        endfunction

        function void note_accepted_word(t_in_word w);
            t_out_word r;
            r = '0;
            if (w.op == OP_ENQUEUE) begin
                if (queue_full) begin
                    r.status = STAT_REFUSED_FULL;
                    n_refused++;
                end else begin
                    slot_addr[wr_idx] = w.msg_addr;
                    slot_len[wr_idx]  = w.msg_length;
                    wr_idx = (wr_idx + 1) % QDEPTH;
                    if (wr_idx == rd_idx) begin
                        queue_full = 1;
                        n_full_hits++;
                    end
                    r.status = STAT_ENQUEUED;
                    n_enqueued++;
                    if (!tx_busy) begin
                        tx_busy = 1;
                        load_start(r);
                    end
                end
            end else if (!tx_busy) begin
                r.status = STAT_DONE_IGNORED;
                n_ignored++;
            end else begin
                queue_full = 0;
                rd_idx     = (rd_idx + 1) % QDEPTH;
                r.status   = STAT_DONE_RETIRED;
                n_retired++;
                if (rd_idx == wr_idx)
                    tx_busy = 0;
                else
                    load_start(r);
            end
            owed_words.push_back(r);
        endfunction

        function void check_out_word(t_out_word got);
            t_out_word exp;
            if (owed_words.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, got);
                errors++;
                return;
            end
            exp = owed_words.pop_front();
            n_checked++;
            if (got.status !== exp.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.start_valid !== exp.start_valid) begin
                $display("%0t: start_valid mismatch, expected %0b, actual %0b",
                         $time, exp.start_valid, got.start_valid);
                errors++;
            end
            if (got.start_addr !== exp.start_addr) begin
                $display("%0t: start_addr mismatch, expected %h, actual %h",
                         $time, exp.start_addr, got.start_addr);
                errors++;
            end
            if (got.start_length !== exp.start_length) begin
                $display("%0t: start_length mismatch, expected %h, actual %h",
                         $time, exp.start_length, got.start_length);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      in_valid    = 1'b0;
    t_in_word  in_word     = '0;
    logic      out_stall   = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    descriptor_ring_model ring_model = new();

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 0;
    int  hold_count     = 0;

    tx_descriptor_queue #(
        .QUEUE_DEPTH (QDEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic set_idle_phase(input t_idle_phase ph);
        case (ph)
            IDLE_NONE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct  = 64;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct  = 0;
                recv_stall_pct = 64;
            end
            default: begin
                send_idle_pct  = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    // offer one word from a falling edge, hold it until a rising edge takes
    // it, then return on the next falling edge; valid is only lowered for a
    // real gap so it is never dropped and raised in one step
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ring_model.note_accepted_word(w);
        @(negedge i_clk);
    endtask

    function automatic t_in_word make_enqueue(input logic [ADDR_W-1:0] addr,
                                              input logic [LENGTH_W-1:0] len);
        t_in_word w;
        w.op         = OP_ENQUEUE;
        w.msg_addr   = addr;
        w.msg_length = len;
        return w;
    endfunction

    // done words carry random junk in the descriptor fields
    function automatic t_in_word make_random_word(input int enq_pct);
        t_in_word w;
        w.msg_addr   = $urandom;
        w.msg_length = LENGTH_W'($urandom_range(16'hffff));
        case ($urandom_range(15))
            0: w.msg_addr = '0;
            1: w.msg_addr = '1;
            2: w.msg_length = '0;
            3: w.msg_length = '1;
            default: ;
        endcase
        w.op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DONE;
        return w;
    endfunction

    // receiver side: random stall at the falling edge, or one long hold-off
    // counted here so the output register and then the input back up
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                hold_count++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // result check at the rising edge where the receiver takes a word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            ring_model.check_out_word(o_out_word);
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d words still owed",
                         $time, quiet_cycles, ring_model.owed_words.size());
                $display("tx_descriptor_queue test failed");
                $finish;
            end
        end
    end

    initial begin
        int       seg;
        int       n_sent;
        int       enq_pct;
        int       enq_mix [4];
        t_in_word w;

        enq_mix = '{95, 20, 80, 50};
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: done while idle, field extremes, a start on the first
        // enqueue, retires that start the next one, drain to empty, then
        // done while idle again
        set_idle_phase(IDLE_NONE);
        w = make_enqueue('0, '0);
        w.op = OP_DONE;
        send_word(w);
        send_word(make_enqueue(32'h0000_0000, 16'h0000));
        send_word(make_enqueue(32'hffff_ffff, 16'hffff));
        send_word(make_enqueue(32'h5555_5555, 16'haaaa));
        send_word(make_enqueue(32'haaaa_aaaa, 16'h5555));
        w.msg_addr   = '1;
        w.msg_length = '1;
        repeat (5) send_word(w);
        send_word(make_enqueue(32'h8000_0001, 16'h8001));
        send_word(w);

        // random: segments rotate the idling pattern and the enqueue share,
        // so the ring fills, refuses, retires from full and drains to idle
        seg    = 0;
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS) begin
            set_idle_phase(t_idle_phase'(seg % 4));
            enq_pct = enq_mix[(seg / 4) % 4];
            // first segment: sender always offering while the receiver holds off
            if (seg == 0)
                hold_request = 1;
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                w = make_random_word(enq_pct);
                n_sent++;
                send_word(w);
            end
            seg++;
        end
        in_valid <= 1'b0;
        set_idle_phase(IDLE_NONE);

        while (ring_model.owed_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d enqueues, %0d refused, %0d fills, %0d retires, %0d ignored",
                 ring_model.n_enqueued, ring_model.n_refused, ring_model.n_full_hits,
                 ring_model.n_retired, ring_model.n_ignored);
        $display("%0d words checked, %0d starts, %0d long hold-offs, %0d mismatches",
                 ring_model.n_checked, ring_model.n_starts, hold_count, ring_model.errors);
        if (ring_model.errors == 0 && ring_model.owed_words.size() == 0) begin
            $display("tx_descriptor_queue test passed");
        end else begin
            $display("tx_descriptor_queue test failed");
        end
        $finish;
    end

endmodule
